### hdl/s5hs_pkg.sv
// Shared types, codes and sizes for the SOCKS5 handshake parser.
package s5hs_pkg;

  localparam int unsigned BUFFER_BYTES_DEFAULT = 512;
  localparam int unsigned QUEUE_DEPTH_DEFAULT  = 4;

  // Result kinds.
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_CONN  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_ILLEGAL = 2'd0;
  localparam logic [1:0] ERR_NOAUTH  = 2'd1;
  localparam logic [1:0] ERR_BADCMD  = 2'd2;
  localparam logic [1:0] ERR_BADVER  = 2'd3;

  // Reported address types.
  localparam logic [1:0] ATYPE_IPV4   = 2'd0;
  localparam logic [1:0] ATYPE_DOMAIN = 2'd1;
  localparam logic [1:0] ATYPE_IPV6   = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] SOCKS_VERSION   = 8'd5;
  localparam logic [7:0] SOCKS_CONNECT   = 8'd1;
  localparam logic [7:0] WIRE_ATYP_IPV4  = 8'd1;
  localparam logic [7:0] WIRE_ATYP_NAME  = 8'd3;
  localparam logic [7:0] WIRE_ATYP_IPV6  = 8'd4;
  localparam logic [7:0] METHOD_NOAUTH   = 8'd0;

  // Success reply lengths, as the index of the final byte.
  localparam logic [4:0] REPLY_LAST_IPV4 = 5'd9;
  localparam logic [4:0] REPLY_LAST_IPV6 = 5'd21;
  localparam logic [4:0] REPLY_ATYP_POS  = 5'd3;

  // What the check at a chunk end decided.
  typedef enum logic [1:0] {
    CHK_NONE  = 2'd0,
    CHK_GREET = 2'd1,
    CHK_CONN  = 2'd2,
    CHK_ERR   = 2'd3
  } check_t;

  // One queued item: everything the back end needs to emit its results.
  typedef struct packed {
    logic        reply_cmd;
    logic        reply_ipv6;
    logic        has_addr;
    logic [7:0]  addr_byte;
    logic [1:0]  atype;
    check_t      check;
    logic [15:0] port;
    logic [1:0]  err;
  } entry_t;

endpackage

### hdl/socks5_handshake_parser_unit.sv
// Top level of the SOCKS5 server handshake parser (no-auth method only).
// The block takes one client item per cycle on the item channel and runs the
// SOCKS5 greeting and CONNECT request checks at each chunk end, sending the
// 05 00 greeting reply, tentative destination address bytes, a connected
// report with the port, or an error on the result channel. An item with
// cmd set builds the zero-filled success reply (10 bytes for IPv4, 22 for
// IPv6) without touching the handshake state. The front end updates the
// parse state in the cycle an item is accepted, so items enter back to back
// at one per cycle. The back end emits one result item per cycle from its
// output register while result_stall is low; an item that causes k results
// stays at the queue head until all k are out (a success reply 10 or 22, a
// greeting reply 2, an address byte plus a check 2, most others 1 or none).
// A queue of QueueDepth classified items absorbs these bursts, and item_stall
// rises only when that queue is full. Bytes beyond BufferBytes in one phase
// are not counted and make the next chunk end report an illegal request.
// After connected or an error, data items are taken and dropped until reset.
module socks5_handshake_parser_unit #(
  parameter int unsigned BufferBytes = s5hs_pkg::BUFFER_BYTES_DEFAULT,
  parameter int unsigned QueueDepth  = s5hs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic        chunk_end,
  input  logic        reply_ipv6,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [15:0] dest_port,
  output logic [1:0]  addr_type,
  output logic [1:0]  error_code,
  output logic        last
);
  import s5hs_pkg::*;

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   full;
  logic   head_valid;
  entry_t head;

  // The queue full flag is the only back pressure on the item side.
  assign item_stall = full;
  assign accept     = item_valid && !full;

  s5hs_front #(
    .BufferBytes(BufferBytes)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .chunk_end  (chunk_end),
    .reply_ipv6 (reply_ipv6),
    .push       (push),
    .push_entry (push_entry)
  );

  s5hs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  s5hs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .dest_port    (dest_port),
    .addr_type    (addr_type),
    .error_code   (error_code),
    .last         (last)
  );

endmodule

### hdl/s5hs_front.sv
// Front end: accepts items, tracks the handshake state and classifies each item.
module s5hs_front #(
  parameter int unsigned BufferBytes = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  input  logic              chunk_end,
  input  logic              reply_ipv6,
  output logic              push,
  output s5hs_pkg::entry_t  push_entry
);
  import s5hs_pkg::*;

  localparam int unsigned CountW = $clog2(BufferBytes + 1);

  typedef enum logic [3:0] {
    PH_GREET = 4'b0001,
    PH_REQ   = 4'b0010,
    PH_CONN  = 4'b0100,
    PH_ERR   = 4'b1000
  } phase_t;

  function automatic logic [1:0] atype_code(input logic [7:0] t);
    if (t == WIRE_ATYP_NAME) return ATYPE_DOMAIN;
    if (t == WIRE_ATYP_IPV6) return ATYPE_IPV6;
    return ATYPE_IPV4;
  endfunction

  phase_t            phase, phase_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [7:0]        version_seen, version_seen_next;
  logic [7:0]        method_count, method_count_next;
  logic              noauth_seen, noauth_seen_next;
  logic [7:0]        command_seen, command_seen_next;
  logic [7:0]        reserved_seen, reserved_seen_next;
  logic [7:0]        addr_type_seen, addr_type_seen_next;
  logic [7:0]        name_length, name_length_next;
  logic [15:0]       port_shift, port_shift_next;
  logic              overflow, overflow_next;

  logic [CountW-1:0] idx;
  logic [CountW-1:0] method_end;
  logic [CountW-1:0] name_end;
  logic [CountW-1:0] need;
  logic              need_ok;
  entry_t            entry;

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    version_seen_next   = version_seen;
    method_count_next   = method_count;
    noauth_seen_next    = noauth_seen;
    command_seen_next   = command_seen;
    reserved_seen_next  = reserved_seen;
    addr_type_seen_next = addr_type_seen;
    name_length_next    = name_length;
    port_shift_next     = port_shift;
    overflow_next       = overflow;
    entry               = '0;
    entry.check         = CHK_NONE;
    push                = 1'b0;
    idx                 = byte_count;
    method_end          = CountW'(method_count) + CountW'(2);
    name_end            = CountW'(name_length) + CountW'(5);
    need                = '0;
    need_ok             = 1'b0;

    if (accept && cmd) begin
      push             = 1'b1;
      entry.reply_cmd  = 1'b1;
      entry.reply_ipv6 = reply_ipv6;
    end else if (accept && (phase == PH_GREET || phase == PH_REQ)) begin
      if (byte_count >= CountW'(BufferBytes)) begin
        overflow_next = 1'b1;
      end else begin
        byte_count_next = byte_count + CountW'(1);
      end

      if (!overflow_next) begin
        if (idx == CountW'(0)) version_seen_next = data_byte;
        if (phase == PH_GREET) begin
          if (idx == CountW'(1)) method_count_next = data_byte;
          if (idx >= CountW'(2) && idx < method_end && data_byte == METHOD_NOAUTH) begin
            noauth_seen_next = 1'b1;
          end
        end else begin
          if (idx == CountW'(1)) command_seen_next = data_byte;
          if (idx == CountW'(2)) reserved_seen_next = data_byte;
          if (idx == CountW'(3)) addr_type_seen_next = data_byte;
          if (idx == CountW'(4)) name_length_next = data_byte;
          port_shift_next = {port_shift[7:0], data_byte};
          // Address bytes pass out as they arrive, before any check.
          if ((addr_type_seen == WIRE_ATYP_IPV4 && idx >= CountW'(4) && idx < CountW'(8)) ||
              (addr_type_seen == WIRE_ATYP_IPV6 && idx >= CountW'(4) && idx < CountW'(20)) ||
              (addr_type_seen == WIRE_ATYP_NAME && idx >= CountW'(5) && idx < name_end)) begin
            entry.has_addr  = 1'b1;
            entry.addr_byte = data_byte;
            entry.atype     = atype_code(addr_type_seen);
          end
        end
      end

      if (chunk_end) begin
        if (overflow_next) begin
          entry.check = CHK_ERR;
          entry.err   = ERR_ILLEGAL;
        end else if (phase == PH_GREET) begin
          need = CountW'(method_count_next) + CountW'(2);
          if (byte_count_next < CountW'(3)) begin
            entry.check = CHK_NONE;
          end else if (version_seen_next != SOCKS_VERSION) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_BADVER;
          end else if (byte_count_next < need) begin
            entry.check = CHK_NONE;
          end else if (byte_count_next > need) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_ILLEGAL;
          end else if (!noauth_seen_next) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_NOAUTH;
          end else begin
            entry.check = CHK_GREET;
          end
        end else begin
          need_ok = 1'b1;
          if (addr_type_seen_next == WIRE_ATYP_IPV4) begin
            need = CountW'(10);
          end else if (addr_type_seen_next == WIRE_ATYP_NAME) begin
            need = CountW'(name_length_next) + CountW'(7);
          end else if (addr_type_seen_next == WIRE_ATYP_IPV6) begin
            need = CountW'(22);
          end else begin
            need_ok = 1'b0;
          end
          if (byte_count_next < CountW'(10)) begin
            entry.check = CHK_NONE;
          end else if (version_seen_next != SOCKS_VERSION) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_BADVER;
          end else if (command_seen_next != SOCKS_CONNECT) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_BADCMD;
          end else if (reserved_seen_next != 8'd0 || !need_ok) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_ILLEGAL;
          end else if (byte_count_next < need) begin
            entry.check = CHK_NONE;
          end else if (byte_count_next > need) begin
            entry.check = CHK_ERR;
            entry.err   = ERR_ILLEGAL;
          end else begin
            entry.check = CHK_CONN;
            entry.port  = port_shift_next;
            entry.atype = atype_code(addr_type_seen_next);
          end
        end
      end

      unique case (entry.check)
        CHK_ERR:   phase_next = PH_ERR;
        CHK_CONN:  phase_next = PH_CONN;
        CHK_GREET: begin
          phase_next          = PH_REQ;
          byte_count_next     = '0;
          version_seen_next   = '0;
          method_count_next   = '0;
          noauth_seen_next    = 1'b0;
          command_seen_next   = '0;
          reserved_seen_next  = '0;
          addr_type_seen_next = '0;
          name_length_next    = '0;
          port_shift_next     = '0;
          overflow_next       = 1'b0;
        end
        default:   phase_next = phase;
      endcase

      push = entry.has_addr || (entry.check != CHK_NONE);
    end
  end

  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_GREET;
      byte_count     <= '0;
      version_seen   <= '0;
      method_count   <= '0;
      noauth_seen    <= 1'b0;
      command_seen   <= '0;
      reserved_seen  <= '0;
      addr_type_seen <= '0;
      name_length    <= '0;
      port_shift     <= '0;
      overflow       <= 1'b0;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      version_seen   <= version_seen_next;
      method_count   <= method_count_next;
      noauth_seen    <= noauth_seen_next;
      command_seen   <= command_seen_next;
      reserved_seen  <= reserved_seen_next;
      addr_type_seen <= addr_type_seen_next;
      name_length    <= name_length_next;
      port_shift     <= port_shift_next;
      overflow       <= overflow_next;
    end
  end

endmodule

### hdl/s5hs_queue.sv
// Small register queue of classified items between the front and back ends.
module s5hs_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  s5hs_pkg::entry_t  push_entry,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output s5hs_pkg::entry_t  head
);
  import s5hs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

endmodule

### hdl/s5hs_back.sv
// Back end: expands queued items into result items through an output register.
module s5hs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  s5hs_pkg::entry_t  head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        kind,
  output logic [7:0]        out_byte,
  output logic [15:0]       dest_port,
  output logic [1:0]        addr_type,
  output logic [1:0]        error_code,
  output logic              last
);
  import s5hs_pkg::*;

  logic [4:0]  reply_index;
  logic        load;
  logic        fin;
  logic [1:0]  r_kind;
  logic [7:0]  r_byte;
  logic [15:0] r_port;
  logic [1:0]  r_atype;
  logic [1:0]  r_err;

  assign load = head_valid && (!result_valid || !result_stall);
  assign pop  = load && fin;

  always_comb begin
    r_kind  = KIND_REPLY;
    r_byte  = '0;
    r_port  = '0;
    r_atype = ATYPE_IPV4;
    r_err   = ERR_ILLEGAL;
    fin     = 1'b1;
    if (head.reply_cmd) begin
      if (reply_index == 5'd0) begin
        r_byte = SOCKS_VERSION;
      end else if (reply_index == REPLY_ATYP_POS) begin
        r_byte = head.reply_ipv6 ? WIRE_ATYP_IPV6 : WIRE_ATYP_IPV4;
      end
      fin = (reply_index == (head.reply_ipv6 ? REPLY_LAST_IPV6 : REPLY_LAST_IPV4));
    end else if (head.has_addr && reply_index == 5'd0) begin
      r_kind  = KIND_ADDR;
      r_byte  = head.addr_byte;
      r_atype = head.atype;
      fin     = (head.check == CHK_NONE);
    end else begin
      unique case (head.check)
        CHK_GREET: begin
          r_byte = (reply_index == 5'd0) ? SOCKS_VERSION : METHOD_NOAUTH;
          fin    = (reply_index == 5'd1);
        end
        CHK_CONN: begin
          r_kind  = KIND_CONN;
          r_port  = head.port;
          r_atype = head.atype;
        end
        CHK_ERR: begin
          r_kind = KIND_ERR;
          r_err  = head.err;
        end
        default: fin = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      reply_index  <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      reply_index  <= fin ? 5'd0 : reply_index + 5'd1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= r_kind;
      out_byte   <= r_byte;
      dest_port  <= r_port;
      addr_type  <= r_atype;
      error_code <= r_err;
      last       <= fin;
    end
  end

endmodule
